FILE: hdl/sprobit_pkg.sv
// Shared types, constants and fixed-point helpers of the scaled probit core.
package sprobit_pkg;

  localparam int FRAC_BITS = 16;
  localparam int Q_W       = 8;
  localparam int BETA_W    = 32;
  localparam int Z_W       = FRAC_BITS + 5;
  localparam int CDF_W     = FRAC_BITS + 1;
  localparam int PDF_W     = 15;
  localparam int RES_W     = 32;
  localparam int ZLIM      = 1 << (FRAC_BITS + 3);

  localparam int OUT_BITS  = Z_W + CDF_W + PDF_W + 7 * RES_W;
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE  = 2'd2;

  typedef struct packed {
    logic        [Q_W-1:0] q;
    logic signed [Z_W-1:0] z;
  } lut_req_t;

  typedef struct packed {
    logic        [Q_W-1:0]   q;
    logic signed [Z_W-1:0]   z;
    logic        [CDF_W-1:0] cdf;
    logic        [PDF_W-1:0] pdf;
  } lut_rsp_t;

  function automatic logic signed [RES_W-1:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[RES_W-1:0];
  endfunction

  // Drop FRAC_BITS, nearest with ties away from zero, then clamp.
  // A negative value rounds as (v + half - 1) >>> FRAC_BITS.
  function automatic logic signed [RES_W-1:0] rnd_sat(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = v + (64'sd1 <<< (FRAC_BITS - 1)) - (v[63] ? 64'sd1 : 64'sd0);
    t = t >>> FRAC_BITS;
    return sat32(t);
  endfunction

endpackage

FILE: hdl/scaled_probit_with_derivatives_core.sv
// Scaled probit link with derivative terms: top level, front and product pipelines.
// Pipeline: 14 register stages (2 predictor, 4 table, 8 product); out_tvalid rises once
// an accepted request has passed them all. Throughput: one request per cycle unless out_tready holds it.
// A stage advances when empty or when its successor advances, so bubbles close and the
// input stalls only once every stage holds a request behind a low out_tready.
// Reset (rst_n low, synchronous) clears valid bits and betas; the tables are ROM.
module scaled_probit_with_derivatives_core #(
  parameter int MAX_QUALITY  = 255,
  parameter int TABLE_POINTS = 1025
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Configuration write port
  input  logic                                  cfg_we,
  input  logic [sprobit_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sprobit_pkg::BETA_W-1:0]        cfg_data,
  // Input requests
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [7:0]                            in_tdata,   // quality[7:0]
  // Results
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // z_value[20:0], cdf_value[37:21], pdf_value[52:38], eta_term[84:53],
  // pdf_times_q[116:85], pdf_times_scale[148:117], pdf_scale_q[180:149],
  // pdf_scale_z[212:181], pdf_scale_q_z[244:213], pdf_scale_q2_z[276:245], zeros above
  output logic [sprobit_pkg::OUT_W-1:0]         out_tdata
);

  localparam int Q_W    = sprobit_pkg::Q_W;
  localparam int Z_W    = sprobit_pkg::Z_W;
  localparam int CDF_W  = sprobit_pkg::CDF_W;
  localparam int PDF_W  = sprobit_pkg::PDF_W;
  localparam int RES_W  = sprobit_pkg::RES_W;
  localparam int BETA_W = sprobit_pkg::BETA_W;
  localparam int NB     = 8;
  localparam int ZP_W   = BETA_W + Q_W + 1;
  localparam int ZS_W   = ZP_W + 1;

  // Quality clamp limit, held to what the 8-bit field can carry
  localparam logic [Q_W-1:0] Q_LIM = (MAX_QUALITY > 255) ? 8'd255 : Q_W'(MAX_QUALITY);

  localparam logic signed [ZS_W-1:0] Z_HI = ZS_W'(sprobit_pkg::ZLIM);
  localparam logic signed [ZS_W-1:0] Z_LO = -ZS_W'(sprobit_pkg::ZLIM);

  // Per-request payload of the product pipeline; each stage fills a few fields
  typedef struct packed {
    logic        [Q_W-1:0]    q;
    logic signed [Z_W-1:0]    z;
    logic        [CDF_W-1:0]  cdf;
    logic        [PDF_W-1:0]  pdf;
    logic        [49:0]       eta_p;
    logic        [47:0]       ps_p;
    logic        [22:0]       pq;
    logic signed [RES_W-1:0]  eta;
    logic signed [RES_W-1:0]  ps;
    logic        [40:0]       psq_p;
    logic        [52:0]       psz_p;
    logic signed [RES_W-1:0]  psq;
    logic signed [RES_W-1:0]  psz;
    logic        [52:0]       psqz_p;
    logic signed [RES_W-1:0]  psqz;
    logic        [40:0]       q2_p;
    logic signed [RES_W-1:0]  psq2z;
  } back_t;

  // Beta registers, Q16.16
  logic signed [BETA_W-1:0] beta_scale_r;
  logic signed [BETA_W-1:0] beta_offset_r;
  logic signed [BETA_W-1:0] beta_slope_r;

  // Front: slope product, then offset add and saturation
  logic [1:0]              f_v_r;
  logic [1:0]              f_en;
  logic [Q_W-1:0]          q_cl;
  logic [Q_W-1:0]          f0_q_r;
  logic signed [ZP_W-1:0]  f0_zp_r;
  logic signed [ZS_W-1:0]  zsum;
  logic signed [Z_W-1:0]   z_nxt;
  sprobit_pkg::lut_req_t   f1_req_r;

  // Table lookup handshake
  logic                    lut_ready;
  logic                    lut_valid;
  sprobit_pkg::lut_rsp_t   lut_rsp;

  // Back: products, rounding and saturation
  logic [NB-1:0]           b_v_r;
  logic [NB-1:0]           b_en;
  back_t                   b_r   [NB];
  back_t                   b_nxt [NB];

  // Take a register write at any enabled edge; drop unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beta_scale_r  <= '0;
      beta_offset_r <= '0;
      beta_slope_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sprobit_pkg::REG_SCALE:  beta_scale_r  <= cfg_data;
        sprobit_pkg::REG_OFFSET: beta_offset_r <= cfg_data;
        sprobit_pkg::REG_SLOPE:  beta_slope_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage enables: a stage moves when empty or when the one after it moves
  always_comb begin
    f_en[1] = !f_v_r[1] || lut_ready;
    f_en[0] = !f_v_r[0] || f_en[1];
  end

  always_comb begin
    b_en[NB-1] = !b_v_r[NB-1] || out_tready;
    for (int i = NB - 2; i >= 0; i--) begin
      b_en[i] = !b_v_r[i] || b_en[i+1];
    end
  end

  assign in_tready = f_en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= '0;
      b_v_r <= '0;
    end else begin
      if (f_en[0]) f_v_r[0] <= in_tvalid;
      if (f_en[1]) f_v_r[1] <= f_v_r[0];
      if (b_en[0]) b_v_r[0] <= lut_valid;
      for (int i = 1; i < NB; i++) begin
        if (b_en[i]) b_v_r[i] <= b_v_r[i-1];
      end
    end
  end

  // Front stage 0: clamp quality, multiply by slope
  assign q_cl = (in_tdata > Q_LIM) ? Q_LIM : in_tdata;

  always_ff @(posedge clk) begin
    if (f_en[0]) begin
      f0_q_r  <= q_cl;
      f0_zp_r <= ZP_W'(beta_slope_r) * ZP_W'($signed({1'b0, q_cl}));
    end
  end

  // Front stage 1: add offset, hold z within plus or minus eight
  always_comb begin
    zsum = ZS_W'(beta_offset_r) + ZS_W'(f0_zp_r);
    if (zsum > Z_HI) begin
      z_nxt = Z_W'(Z_HI);
    end else if (zsum < Z_LO) begin
      z_nxt = Z_W'(Z_LO);
    end else begin
      z_nxt = zsum[Z_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (f_en[1]) begin
      f1_req_r.q <= f0_q_r;
      f1_req_r.z <= z_nxt;
    end
  end

  sprobit_lut #(
    .TABLE_POINTS (TABLE_POINTS)
  ) u_lut (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (f_v_r[1]),
    .up_ready (lut_ready),
    .up_req   (f1_req_r),
    .dn_valid (lut_valid),
    .dn_ready (b_en[0]),
    .dn_rsp   (lut_rsp)
  );

  // Product pipeline: stages of multiplies alternate with stages that round or
  // saturate those products; pdf times q is passed on without either.
  always_comb begin
    b_nxt[0]       = '0;
    b_nxt[0].q     = lut_rsp.q;
    b_nxt[0].z     = lut_rsp.z;
    b_nxt[0].cdf   = lut_rsp.cdf;
    b_nxt[0].pdf   = lut_rsp.pdf;
    b_nxt[0].eta_p = 50'(beta_scale_r) * 50'($signed({1'b0, lut_rsp.cdf}));
    b_nxt[0].ps_p  = 48'(beta_scale_r) * 48'($signed({1'b0, lut_rsp.pdf}));
    b_nxt[0].pq    = 23'(lut_rsp.pdf) * 23'(lut_rsp.q);

    for (int i = 1; i < NB; i++) begin
      b_nxt[i] = b_r[i-1];
    end

    // Scale times CDF and density times scale, rounded
    b_nxt[1].eta    = sprobit_pkg::rnd_sat(64'($signed(b_r[0].eta_p)));
    b_nxt[1].ps     = sprobit_pkg::rnd_sat(64'($signed(b_r[0].ps_p)));
    // ps times q and ps times z
    b_nxt[2].psq_p  = 41'(b_r[1].ps) * 41'($signed({1'b0, b_r[1].q}));
    b_nxt[2].psz_p  = 53'(b_r[1].ps) * 53'(b_r[1].z);
    b_nxt[3].psq    = sprobit_pkg::sat32(64'($signed(b_r[2].psq_p)));
    b_nxt[3].psz    = sprobit_pkg::rnd_sat(64'($signed(b_r[2].psz_p)));
    // psq times z
    b_nxt[4].psqz_p = 53'(b_r[3].psq) * 53'(b_r[3].z);
    b_nxt[5].psqz   = sprobit_pkg::rnd_sat(64'($signed(b_r[4].psqz_p)));
    // psqz times q, no rounding
    b_nxt[6].q2_p   = 41'(b_r[5].psqz) * 41'($signed({1'b0, b_r[5].q}));
    b_nxt[7].psq2z  = sprobit_pkg::sat32(64'($signed(b_r[6].q2_p)));
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NB; i++) begin
      if (b_en[i]) b_r[i] <= b_nxt[i];
    end
  end

  // Last product stage doubles as the output register
  assign out_tvalid = b_v_r[NB-1];
  assign out_tdata  = {
    (sprobit_pkg::OUT_W - sprobit_pkg::OUT_BITS)'(0),
    b_r[NB-1].psq2z,
    b_r[NB-1].psqz,
    b_r[NB-1].psz,
    b_r[NB-1].psq,
    b_r[NB-1].ps,
    RES_W'(b_r[NB-1].pq),
    b_r[NB-1].eta,
    b_r[NB-1].pdf,
    b_r[NB-1].cdf,
    b_r[NB-1].z
  };

endmodule

FILE: hdl/sprobit_lut.sv
// Normal CDF and density lookup with linear interpolation, four pipeline stages.
module sprobit_lut #(
  parameter int TABLE_POINTS = 1025
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  sprobit_pkg::lut_req_t up_req,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output sprobit_pkg::lut_rsp_t dn_rsp
);

  localparam int FB     = sprobit_pkg::FRAC_BITS;
  localparam int Z_W    = sprobit_pkg::Z_W;
  localparam int CDF_W  = sprobit_pkg::CDF_W;
  localparam int PDF_W  = sprobit_pkg::PDF_W;
  localparam int ROM_W  = CDF_W + PDF_W;
  localparam int IDX_W  = $clog2(TABLE_POINTS);
  localparam int DEN_SH = FB + 4;
  localparam int NUM_W  = Z_W + IDX_W;
  localparam int WGT_W  = DEN_SH + 1;
  localparam int PRD_W  = CDF_W + WGT_W;
  localparam int LAST   = TABLE_POINTS - 1;

  // Table generation constants (Q2.30 working format)
  localparam int          WB       = 30;
  localparam logic [63:0] ONE_W    = 64'd1 << WB;
  localparam logic [63:0] INV_S2PI = 64'd428361012;
  localparam logic [63:0] GRID_M   = 64'(2 * (TABLE_POINTS - 1));
  localparam logic [63:0] GRID_SQ  = GRID_M * GRID_M;
  localparam logic [63:0] SIMP_DEN = 64'(6 * (TABLE_POINTS - 1));
  localparam logic [63:0] CDF_ONE  = 64'd1 << FB;

  typedef logic [ROM_W-1:0] rom_t [TABLE_POINTS];

  function automatic logic [63:0] div_small(input logic [63:0] x, input logic [4:0] k);
    case (k)
      5'd2:    return x / 64'd2;
      5'd3:    return x / 64'd3;
      5'd4:    return x / 64'd4;
      5'd5:    return x / 64'd5;
      5'd6:    return x / 64'd6;
      5'd7:    return x / 64'd7;
      5'd8:    return x / 64'd8;
      5'd9:    return x / 64'd9;
      5'd10:   return x / 64'd10;
      5'd11:   return x / 64'd11;
      5'd12:   return x / 64'd12;
      5'd13:   return x / 64'd13;
      5'd14:   return x / 64'd14;
      5'd15:   return x / 64'd15;
      5'd16:   return x / 64'd16;
      5'd17:   return x / 64'd17;
      5'd18:   return x / 64'd18;
      5'd19:   return x / 64'd19;
      5'd20:   return x / 64'd20;
      5'd21:   return x / 64'd21;
      5'd22:   return x / 64'd22;
      5'd23:   return x / 64'd23;
      5'd24:   return x / 64'd24;
      default: return x;
    endcase
  endfunction

  // exp(-f) for f in [0,1], 24-term Taylor sum, truncated products
  function automatic logic [63:0] exp_neg_w(input logic [63:0] f);
    longint      sum;
    logic [63:0] term;
    sum  = longint'(ONE_W);
    term = ONE_W;
    for (int k = 1; k <= 24; k++) begin
      term = div_small((term * f) >> WB, 5'(k));
      if (k[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    return (sum < 0) ? 64'd0 : 64'(sum);
  endfunction

  // Density at x = 8*d/GRID_M
  function automatic logic [63:0] gauss_w(input logic [63:0] d, input logic [63:0] em1);
    logic [63:0] t;
    logic [63:0] n;
    logic [63:0] e;
    t = ((64'd32 * d * d) << WB) / GRID_SQ;
    n = t >> WB;
    e = exp_neg_w(t & (ONE_W - 64'd1));
    for (int i = 0; i < 32; i++) begin
      if (64'(i) < n) begin
        e = (e * em1) >> WB;
      end
    end
    return (e * INV_S2PI + (ONE_W >> 1)) >> WB;
  endfunction

  function automatic logic [63:0] absdiff(input logic [63:0] a, input logic [63:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [63:0] w_to_out(input logic [63:0] v);
    return (v + (64'd1 << (WB - 1 - FB))) >> (WB - FB);
  endfunction

  // Word layout: density in the upper bits, CDF in the lower bits.
  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] acc;
    logic [63:0] prev;
    logic [63:0] mid;
    logic [63:0] nxt;
    logic [63:0] em1;
    logic [63:0] c;
    logic [63:0] p;
    acc  = 64'd0;
    em1  = exp_neg_w(ONE_W);
    prev = gauss_w(GRID_M, em1);
    for (int k = 0; k < TABLE_POINTS; k++) begin
      c = w_to_out(acc / SIMP_DEN);
      if (c > CDF_ONE) begin
        c = CDF_ONE;
      end
      p = w_to_out(prev);
      rom[k] = {p[PDF_W-1:0], c[CDF_W-1:0]};
      if (k + 1 < TABLE_POINTS) begin
        mid  = gauss_w(absdiff(64'(4 * k + 2), GRID_M), em1);
        nxt  = gauss_w(absdiff(64'(4 * k + 4), GRID_M), em1);
        acc  = acc + 64'd16 * (prev + 64'd4 * mid + nxt);
        prev = nxt;
      end
    end
    return rom;
  endfunction

  localparam rom_t LUT_ROM = build_rom();

  logic [3:0] v_r;
  logic [3:0] en;

  // Stage 0: grid index and interpolation weight
  logic [Z_W-1:0]    u;
  logic [NUM_W-1:0]  num;
  logic [IDX_W-1:0]  idx_nxt;
  logic [DEN_SH-1:0] rem_nxt;

  logic [IDX_W-1:0]      l0_idx_a_r;
  logic [IDX_W-1:0]      l0_idx_b_r;
  logic [DEN_SH-1:0]     l0_rem_r;
  sprobit_pkg::lut_req_t l0_req_r;

  // Stage 1: table words
  logic [ROM_W-1:0]      l1_wa_r;
  logic [ROM_W-1:0]      l1_wb_r;
  logic [DEN_SH-1:0]     l1_rem_r;
  sprobit_pkg::lut_req_t l1_req_r;

  // Stage 2: weighted products
  logic [WGT_W-1:0]      wgt_a;
  logic [PRD_W-1:0]      l2_ca_r;
  logic [PRD_W-1:0]      l2_cb_r;
  logic [PRD_W-1:0]      l2_pa_r;
  logic [PRD_W-1:0]      l2_pb_r;
  sprobit_pkg::lut_req_t l2_req_r;

  // Stage 3: rounded sums
  logic [PRD_W:0]        csum;
  logic [PRD_W:0]        psum;
  sprobit_pkg::lut_rsp_t l3_rsp_r;

  // Advance a stage when it is empty or the next one moves
  always_comb begin
    en[3] = !v_r[3] || dn_ready;
    en[2] = !v_r[2] || en[3];
    en[1] = !v_r[1] || en[2];
    en[0] = !v_r[0] || en[1];
  end

  assign up_ready = en[0];
  assign dn_valid = v_r[3];
  assign dn_rsp   = l3_rsp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= up_valid;
      if (en[1]) v_r[1] <= v_r[0];
      if (en[2]) v_r[2] <= v_r[1];
      if (en[3]) v_r[3] <= v_r[2];
    end
  end

  always_comb begin
    u   = Z_W'($unsigned(up_req.z)) + Z_W'(sprobit_pkg::ZLIM);
    num = NUM_W'(u) * NUM_W'(LAST);
    if (num[NUM_W-1:DEN_SH] >= (IDX_W + 1)'(LAST)) begin
      idx_nxt = IDX_W'(LAST);
      rem_nxt = '0;
    end else begin
      idx_nxt = num[DEN_SH +: IDX_W];
      rem_nxt = num[DEN_SH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      l0_idx_a_r <= idx_nxt;
      l0_idx_b_r <= (idx_nxt == IDX_W'(LAST)) ? idx_nxt : idx_nxt + IDX_W'(1);
      l0_rem_r   <= rem_nxt;
      l0_req_r   <= up_req;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      l1_wa_r  <= LUT_ROM[l0_idx_a_r];
      l1_wb_r  <= LUT_ROM[l0_idx_b_r];
      l1_rem_r <= l0_rem_r;
      l1_req_r <= l0_req_r;
    end
  end

  assign wgt_a = (WGT_W'(1) << DEN_SH) - WGT_W'(l1_rem_r);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      l2_ca_r  <= PRD_W'(l1_wa_r[CDF_W-1:0]) * PRD_W'(wgt_a);
      l2_cb_r  <= PRD_W'(l1_wb_r[CDF_W-1:0]) * PRD_W'(l1_rem_r);
      l2_pa_r  <= PRD_W'(l1_wa_r[ROM_W-1:CDF_W]) * PRD_W'(wgt_a);
      l2_pb_r  <= PRD_W'(l1_wb_r[ROM_W-1:CDF_W]) * PRD_W'(l1_rem_r);
      l2_req_r <= l1_req_r;
    end
  end

  assign csum = (PRD_W + 1)'(l2_ca_r) + (PRD_W + 1)'(l2_cb_r)
              + ((PRD_W + 1)'(1) << (DEN_SH - 1));
  assign psum = (PRD_W + 1)'(l2_pa_r) + (PRD_W + 1)'(l2_pb_r)
              + ((PRD_W + 1)'(1) << (DEN_SH - 1));

  always_ff @(posedge clk) begin
    if (en[3]) begin
      l3_rsp_r.q   <= l2_req_r.q;
      l3_rsp_r.z   <= l2_req_r.z;
      l3_rsp_r.cdf <= csum[DEN_SH +: CDF_W];
      l3_rsp_r.pdf <= psum[DEN_SH +: PDF_W];
    end
  end

endmodule

FILE: tb/sv/tb_scaled_probit_with_derivatives_core.sv
// Self-checking testbench for the scaled probit core: table-built predictor, streamed requests.
module tb_scaled_probit_with_derivatives_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS = sprobit_pkg::FRAC_BITS;
  localparam int ZLIM      = sprobit_pkg::ZLIM;
  localparam int Q_W       = sprobit_pkg::Q_W;
  localparam int BETA_W    = sprobit_pkg::BETA_W;
  localparam int Z_W       = sprobit_pkg::Z_W;
  localparam int CDF_W     = sprobit_pkg::CDF_W;
  localparam int PDF_W     = sprobit_pkg::PDF_W;
  localparam int RES_W     = sprobit_pkg::RES_W;
  localparam int OUT_W     = sprobit_pkg::OUT_W;
  localparam int OUT_BITS  = sprobit_pkg::OUT_BITS;
  localparam int CFG_IDX_W = sprobit_pkg::CFG_IDX_W;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE  = sprobit_pkg::REG_SCALE;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = sprobit_pkg::REG_OFFSET;
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE  = sprobit_pkg::REG_SLOPE;

  localparam int CLK_PERIOD  = 20;
  localparam int MAX_Q       = 255;
  localparam int N_POINTS    = 1025;
  localparam int WB          = 30;                      // fraction bits of the table build
  localparam longint unsigned ONE_W        = 64'd1 << WB;
  localparam longint unsigned INV_SQRT_2PI = 64'd428361012;
  localparam longint DEN     = 64'sd16 << FRAC_BITS;    // width of [-8, 8] in Q16.16
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 150;
  localparam int RAND_PHASES = 12;
  localparam int PHASE_ITEMS = 160;
  localparam int DRAIN_CYCLES = 42;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // Values that can be read straight off the behavior at the edges of the range
  localparam logic [Z_W-1:0]   Z_TOP    = 21'h08_0000;  // +8.0
  localparam logic [Z_W-1:0]   Z_BOTTOM = 21'h18_0000;  // -8.0
  localparam logic [CDF_W-1:0] CDF_ONE  = 17'h1_0000;
  localparam logic [PDF_W-1:0] PDF_PEAK = 15'd26145;    // density at z = 0
  localparam logic [RES_W-1:0] S32_MAX  = 32'h7FFF_FFFF;
  localparam logic [RES_W-1:0] S32_MIN  = 32'h8000_0000;

  // Fields of a directed row whose typed value replaces the predicted one
  localparam logic [3:0] CHK_Z   = 4'b0001;
  localparam logic [3:0] CHK_CDF = 4'b0010;
  localparam logic [3:0] CHK_PDF = 4'b0100;
  localparam logic [3:0] CHK_ETA = 4'b1000;
  localparam logic [3:0] CHK_ALL = 4'b1111;

  // One result, laid out exactly as out_tdata (last member in the lowest bits)
  typedef struct packed {
    logic [OUT_W-OUT_BITS-1:0] pad;
    logic [RES_W-1:0]          pdf_scale_q2_z;
    logic [RES_W-1:0]          pdf_scale_q_z;
    logic [RES_W-1:0]          pdf_scale_z;
    logic [RES_W-1:0]          pdf_scale_q;
    logic [RES_W-1:0]          pdf_times_scale;
    logic [RES_W-1:0]          pdf_times_q;
    logic [RES_W-1:0]          eta_term;
    logic [PDF_W-1:0]          pdf_value;
    logic [CDF_W-1:0]          cdf_value;
    logic [Z_W-1:0]            z_value;
  } link_terms_t;

  typedef enum logic [1:0] {ROW_REGS, ROW_STRAY, ROW_ITEM} row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    logic [31:0]      scale;     // register data; a stray write carries its data here
    logic [31:0]      offset;
    logic [31:0]      slope;
    logic [Q_W-1:0]   q;
    logic [3:0]       typed;
    logic [Z_W-1:0]   z;
    logic [CDF_W-1:0] cdf;
    logic [PDF_W-1:0] pdf;
    logic [RES_W-1:0] eta;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BETA_W-1:0]    cfg_data;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [7:0]           in_tdata;    // quality[7:0]
  logic                 out_tvalid;
  logic                 out_tready;
  logic [OUT_W-1:0]     out_tdata;   // z, cdf, pdf, eta, then the six density products

  // Predictor copy of the tables and of the three beta registers
  longint cdf_tbl [N_POINTS];
  longint pdf_tbl [N_POINTS];
  longint scale_q16;
  longint offset_q16;
  longint slope_q16;

  link_terms_t expected_terms [$];
  link_terms_t want_terms;
  link_terms_t got_terms;
  stim_row_t   plan [$];

  int  requests_sent;
  int  results_checked;
  int  mismatch_count;
  int  settings_loaded;
  int  cycle_count;
  int  gap_left;
  int  hold_left;
  bit  hold_req;
  bit  burst;

  scaled_probit_with_derivatives_core #(
    .MAX_QUALITY  (MAX_Q),
    .TABLE_POINTS (N_POINTS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Table build: Taylor-series Gaussian in Q2.30, Simpson-integrated for the CDF
  // ---------------------------------------------------------------------------

  // exp(-f) for f in Q2.30, 24 truncated Taylor terms
  function automatic longint unsigned exp_neg_q30(longint unsigned f);
    longint          sum;
    longint unsigned term;
    longint unsigned k;
    sum  = $signed(ONE_W);
    term = ONE_W;
    for (k = 1; k <= 24; k++) begin
      term = ((term * f) >> WB) / k;
      if (k[0]) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    return (sum < 0) ? 64'd0 : $unsigned(sum);
  endfunction

  // Standard normal density at x = 8d/m in Q2.30; split x*x/2 into whole and fraction
  function automatic longint unsigned gauss_q30(longint unsigned d, longint unsigned m);
    longint unsigned t, n, e, em1, i;
    t   = ((64'd32 * d * d) << WB) / (m * m);
    n   = t >> WB;
    e   = exp_neg_q30(t & (ONE_W - 64'd1));
    em1 = exp_neg_q30(ONE_W);
    for (i = 0; i < n; i++) begin
      e = (e * em1) >> WB;
    end
    return (e * INV_SQRT_2PI + (ONE_W >> 1)) >> WB;
  endfunction

  function automatic longint unsigned q30_to_q16(longint unsigned v);
    return (v + (64'd1 << (WB - 1 - FRAC_BITS))) >> (WB - FRAC_BITS);
  endfunction

  function automatic longint unsigned dist_u64(longint unsigned a, longint unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic void build_link_tables();
    longint unsigned m, den6, acc, prev, mid, nxt, c, k;
    m    = 64'd2 * (N_POINTS - 1);
    den6 = 64'd6 * (N_POINTS - 1);
    acc  = 0;
    prev = gauss_q30(m, m);
    for (k = 0; k < N_POINTS; k++) begin
      c = q30_to_q16(acc / den6);
      if (c > (64'd1 << FRAC_BITS)) begin
        c = 64'd1 << FRAC_BITS;
      end
      cdf_tbl[k] = $signed(c);
      pdf_tbl[k] = $signed(q30_to_q16(prev));
      if (k + 1 < N_POINTS) begin
        mid  = gauss_q30(dist_u64(64'd4 * k + 64'd2, m), m);
        nxt  = gauss_q30(dist_u64(64'd4 * k + 64'd4, m), m);
        acc  = acc + 64'd16 * (prev + 64'd4 * mid + nxt);
        prev = nxt;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Drop the fraction, nearest with ties away from zero
  function automatic longint round_frac(longint v);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    return (v < 0) ? -mag : mag;
  endfunction

  function automatic longint clamp_s32(longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Linear interpolation between idx and idx+1; the top point stands alone
  function automatic longint sample_table(bit use_cdf, longint idx, longint rem);
    longint a, b;
    a = use_cdf ? cdf_tbl[idx] : pdf_tbl[idx];
    b = a;
    if (idx + 1 < N_POINTS) begin
      b = use_cdf ? cdf_tbl[idx + 1] : pdf_tbl[idx + 1];
    end
    return (a * (DEN - rem) + b * rem + DEN / 2) / DEN;
  endfunction

  function automatic link_terms_t predict_link_terms(logic [Q_W-1:0] quality);
    longint      q, z, num, idx, rem, cdf, pdf, ps, psq, psqz;
    link_terms_t r;
    q = longint'(quality);
    if (q > MAX_Q) begin
      q = MAX_Q;
    end
    z = offset_q16 + slope_q16 * q;
    if (z > ZLIM) begin
      z = ZLIM;
    end
    if (z < -ZLIM) begin
      z = -ZLIM;
    end
    num = (z + ZLIM) * (N_POINTS - 1);
    idx = num / DEN;
    rem = num % DEN;
    if (idx >= N_POINTS - 1) begin
      idx = N_POINTS - 1;
      rem = 0;
    end
    cdf  = sample_table(1'b1, idx, rem);
    pdf  = sample_table(1'b0, idx, rem);
    ps   = clamp_s32(round_frac(pdf * scale_q16));
    psq  = clamp_s32(ps * q);
    psqz = clamp_s32(round_frac(psq * z));
    r = '0;
    r.z_value         = Z_W'(z);
    r.cdf_value       = CDF_W'(cdf);
    r.pdf_value       = PDF_W'(pdf);
    r.eta_term        = RES_W'(clamp_s32(round_frac(scale_q16 * cdf)));
    r.pdf_times_q     = RES_W'(clamp_s32(pdf * q));
    r.pdf_times_scale = RES_W'(ps);
    r.pdf_scale_q     = RES_W'(psq);
    r.pdf_scale_z     = RES_W'(clamp_s32(round_frac(ps * z)));
    r.pdf_scale_q_z   = RES_W'(psqz);
    r.pdf_scale_q2_z  = RES_W'(clamp_s32(psqz * q));
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus rows
  // ---------------------------------------------------------------------------

  function automatic stim_row_t row_item(logic [Q_W-1:0] q, logic [3:0] typed,
                                         logic [Z_W-1:0] z, logic [CDF_W-1:0] cdf,
                                         logic [PDF_W-1:0] pdf, logic [RES_W-1:0] eta);
    stim_row_t r;
    r       = '0;
    r.kind  = ROW_ITEM;
    r.q     = q;
    r.typed = typed;
    r.z     = z;
    r.cdf   = cdf;
    r.pdf   = pdf;
    r.eta   = eta;
    return r;
  endfunction

  function automatic stim_row_t row_regs(row_kind_e kind, logic [31:0] scale,
                                         logic [31:0] offset, logic [31:0] slope);
    stim_row_t r;
    r        = '0;
    r.kind   = kind;
    r.scale  = scale;
    r.offset = offset;
    r.slope  = slope;
    return r;
  endfunction

  // Append one row to the directed plan
  function automatic void add_row(stim_row_t r);
    plan = {plan, r};
  endfunction

  function automatic logic [31:0] pick_corner();
    case ($urandom_range(0, 4))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return 32'h0001_0000;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  function automatic void note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%s", msg);
    end
  endfunction

  function automatic void compare_field(string name, longint unsigned want,
                                        longint unsigned got);
    if (want != got) begin
      note_mismatch($sformatf("result %0d: %s expected 0x%0h, got 0x%0h",
                              results_checked, name, want, got));
    end
  endfunction

  // Sample the result channel at the rising edge; compare with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_terms.size() == 0) begin
        note_mismatch($sformatf("result %0d arrived with no request outstanding: 0x%0h",
                                results_checked, out_tdata));
      end else begin
        want_terms = expected_terms.pop_front();
        got_terms  = out_tdata;
        compare_field("z_value", 64'(want_terms.z_value), 64'(got_terms.z_value));
        compare_field("cdf_value", 64'(want_terms.cdf_value), 64'(got_terms.cdf_value));
        compare_field("pdf_value", 64'(want_terms.pdf_value), 64'(got_terms.pdf_value));
        compare_field("eta_term", 64'(want_terms.eta_term), 64'(got_terms.eta_term));
        compare_field("pdf_times_q", 64'(want_terms.pdf_times_q),
                      64'(got_terms.pdf_times_q));
        compare_field("pdf_times_scale", 64'(want_terms.pdf_times_scale),
                      64'(got_terms.pdf_times_scale));
        compare_field("pdf_scale_q", 64'(want_terms.pdf_scale_q),
                      64'(got_terms.pdf_scale_q));
        compare_field("pdf_scale_z", 64'(want_terms.pdf_scale_z),
                      64'(got_terms.pdf_scale_z));
        compare_field("pdf_scale_q_z", 64'(want_terms.pdf_scale_q_z),
                      64'(got_terms.pdf_scale_q_z));
        compare_field("pdf_scale_q2_z", 64'(want_terms.pdf_scale_q2_z),
                      64'(got_terms.pdf_scale_q2_z));
        compare_field("padding", 64'(want_terms.pad), 64'(got_terms.pad));
      end
      results_checked++;
      // Draw the receiver's pause before the next result
      gap_left = burst ? 0 : $urandom_range(0, 3);
    end
  end

  // Receiver: drive tready at the falling edge; a long hold-off stalls the whole pipe
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog on the whole run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, expected_terms.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side; every task is entered and left at a falling edge
  // ---------------------------------------------------------------------------

  // Offer one request after a random gap (none in a burst); predict its result once it is taken
  task automatic send_request(stim_row_t row, bit hold_after);
    int          gap;
    link_terms_t want;
    gap = burst ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= row.q;
    do @(posedge clk); while (!in_tready);
    want = predict_link_terms(row.q);
    // Typed edge values override the predictor for the fields they name
    if (row.typed & CHK_Z) want.z_value = row.z;
    if (row.typed & CHK_CDF) want.cdf_value = row.cdf;
    if (row.typed & CHK_PDF) want.pdf_value = row.pdf;
    if (row.typed & CHK_ETA) want.eta_term = row.eta;
    expected_terms = {expected_terms, want};
    requests_sent++;
    if (hold_after) begin
      hold_req = 1'b1;
    end
    @(negedge clk);
  endtask

  // Drop valid and hold until every outstanding request has its result
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_terms.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Leaves cfg_we high; the caller lowers it after its last write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BETA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_SCALE:  scale_q16  = longint'($signed(data));
      REG_OFFSET: offset_q16 = longint'($signed(data));
      REG_SLOPE:  slope_q16  = longint'($signed(data));
      default:    ;  // unmapped index: the block ignores it
    endcase
    @(negedge clk);
  endtask

  task automatic load_betas(logic [31:0] scale, logic [31:0] offset, logic [31:0] slope);
    wait_idle();
    write_reg(REG_SCALE, scale);
    write_reg(REG_OFFSET, offset);
    write_reg(REG_SLOPE, slope);
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int          phase;
    int          n;
    int          mode;
    logic [31:0] s_val, o_val, sl_val;

    clk        = 1'b0;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    gap_left   = 0;
    hold_left  = 0;
    hold_req   = 1'b0;
    burst      = 1'b0;
    scale_q16  = 0;
    offset_q16 = 0;
    slope_q16  = 0;

    build_link_tables();

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. After reset every beta is zero, so z sits at the table center.
    add_row(row_item(8'h00, CHK_Z | CHK_PDF | CHK_ETA, '0, '0, PDF_PEAK, '0));
    add_row(row_item(8'hFF, CHK_Z | CHK_PDF | CHK_ETA, '0, '0, PDF_PEAK, '0));
    add_row(row_item(8'h55, CHK_Z | CHK_PDF | CHK_ETA, '0, '0, PDF_PEAK, '0));
    add_row(row_item(8'hAA, CHK_Z | CHK_PDF | CHK_ETA, '0, '0, PDF_PEAK, '0));
    // Offset far above eight: z saturates high and reads the top point unblended
    add_row(row_regs(ROW_REGS, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0));
    add_row(row_item(8'h00, CHK_ALL, Z_TOP, CDF_ONE, '0, S32_MAX));
    add_row(row_item(8'hFF, CHK_ALL, Z_TOP, CDF_ONE, '0, S32_MAX));
    // Offset far below: z saturates low, where the CDF and density are zero
    add_row(row_regs(ROW_REGS, 32'h8000_0000, 32'h8000_0000, 32'h0));
    add_row(row_item(8'h00, CHK_ALL, Z_BOTTOM, '0, '0, '0));
    add_row(row_item(8'hC8, CHK_ALL, Z_BOTTOM, '0, '0, '0));
    // Largest slope: any nonzero q saturates z; most negative scale times one
    add_row(row_regs(ROW_REGS, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF));
    add_row(row_item(8'h00, CHK_Z | CHK_PDF, '0, '0, PDF_PEAK, '0));
    add_row(row_item(8'h01, CHK_ALL, Z_TOP, CDF_ONE, '0, S32_MIN));
    add_row(row_item(8'hFF, CHK_ALL, Z_TOP, CDF_ONE, '0, S32_MIN));
    add_row(row_regs(ROW_REGS, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000));
    add_row(row_item(8'h01, CHK_ALL, Z_BOTTOM, '0, '0, '0));
    // Full scale with a gentle slope: the products run into saturation
    add_row(row_regs(ROW_REGS, 32'h7FFF_FFFF, 32'h0, 32'h0000_1000));
    add_row(row_item(8'h01, 4'h0, '0, '0, '0, '0));
    add_row(row_item(8'h11, 4'h0, '0, '0, '0, '0));
    add_row(row_item(8'h80, 4'h0, '0, '0, '0, '0));
    add_row(row_item(8'hFF, 4'h0, '0, '0, '0, '0));
    // Mid-range settings with a negative scale and offset
    add_row(row_regs(ROW_REGS, 32'hFFFD_0000, 32'hFFFF_0000, 32'h0000_0100));
    add_row(row_item(8'h00, 4'h0, '0, '0, '0, '0));
    add_row(row_item(8'h64, 4'h0, '0, '0, '0, '0));
    add_row(row_item(8'hC8, 4'h0, '0, '0, '0, '0));
    add_row(row_item(8'hFF, 4'h0, '0, '0, '0, '0));
    // A write to the unmapped index must leave the betas alone
    add_row(row_regs(ROW_STRAY, 32'hFFFF_FFFF, 32'h0, 32'h0));
    add_row(row_item(8'h4D, 4'h0, '0, '0, '0, '0));

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_REGS: begin
          load_betas(plan[i].scale, plan[i].offset, plan[i].slope);
        end
        ROW_STRAY: begin
          wait_idle();
          write_reg(REG_UNUSED, plan[i].scale);
          cfg_we <= 1'b0;
        end
        default: begin
          send_request(plan[i], 1'b0);
        end
      endcase
    end

    // Random part: one register setting per phase, random qualities within it
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      mode = (phase == 0) ? 1 : (phase == 3) ? 2 : $urandom_range(0, 3);
      case (mode)
        0: begin
          s_val  = $urandom();
          o_val  = $urandom();
          sl_val = $urandom();
        end
        1: begin
          // Offset within +-12 and slope within +-1/8: z sweeps across the table
          s_val  = int'($urandom_range(0, 1 << 22)) - (1 << 21);
          o_val  = int'($urandom_range(0, 24 << 16)) - (12 << 16);
          sl_val = int'($urandom_range(0, 16'h4000)) - 16'h2000;
        end
        2: begin
          s_val  = pick_corner();
          o_val  = pick_corner();
          sl_val = pick_corner();
        end
        default: begin
          s_val  = $urandom();
          o_val  = int'($urandom_range(0, 16 << 16)) - (8 << 16);
          sl_val = int'($urandom_range(0, 16'h0800)) - 16'h0400;
        end
      endcase
      // Every third phase runs without the random gaps on either side
      burst = (phase % 3 == 1);
      load_betas(s_val, o_val, sl_val);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // Once, pause the sender until the pipeline is empty
        if (phase == 4 && n == PHASE_ITEMS / 2) begin
          wait_idle();
        end
        send_request(row_item(Q_W'($urandom_range(0, 255)), 4'h0, '0, '0, '0, '0),
                     (phase == 2 || phase == 7) && n == 20);
      end
    end

    // Drain, then let any stray result show itself
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d requests under %0d beta settings, %0d results compared",
             requests_sent, settings_loaded, results_checked);
    $display("Receiver hold-offs, sender drain pause and gapless bursts included; %0d mismatches",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
